@@ rtl/bitmap_id_set_pop_min_macros.svh @@
// assertion macros used by the id set datapath
`ifndef BITMAP_ID_SET_POP_MIN_MACROS_SVH
`define BITMAP_ID_SET_POP_MIN_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define BIPM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bipm same-cycle check failed");

// next-cycle implication
`define BIPM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bipm next-cycle check failed");

`endif

@@ rtl/bipm_pkg.sv @@
// shared request codes, widths and controller/datapath interface types
`timescale 1ns / 1ps

package bipm_pkg;

    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 56;
    localparam int PID_W      = 16;
    localparam int CNT_OUT_W  = 17;

    localparam logic [1:0] REQ_MARK  = 2'd0;
    localparam logic [1:0] REQ_QUERY = 2'd1;
    localparam logic [1:0] REQ_POP   = 2'd2;

    typedef struct packed {
        logic load;
        logic look;
        logic scan;
        logic commit;
    } bipm_cmd_t;

    typedef struct packed {
        logic pop_hit;
        logic out_free;
    } bipm_stat_t;

endpackage

@@ rtl/bipm_ctrl.sv @@
// request sequencer: accept, summary lookup, word scan, update
`timescale 1ns / 1ps

module bipm_ctrl
    import bipm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  bipm_stat_t stat,
    output bipm_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOK   = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_UPDATE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                cmd.look = 1'b1;
                // only a pop on a nonempty set needs the second level scan
                state_next = stat.pop_hit ? ST_SCAN : ST_UPDATE;
            end
            ST_SCAN:
            begin
                cmd.scan   = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.commit = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/bipm_dp.sv @@
// datapath: top summary flops, summary and bitmap memories, result register
`timescale 1ns / 1ps
`include "bitmap_id_set_pop_min_macros.svh"

module bipm_dp
    import bipm_pkg::*;
#(
    parameter int ID_BITS   = 16,
    parameter int WORD_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [IN_USER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  bipm_cmd_t             cmd,
    output bipm_stat_t            stat
);

    // bitmap words are WORD_BITS rounded down to a power of two
    localparam int S     = $clog2(WORD_BITS + 1) - 1;
    localparam int DW    = 1 << S;
    localparam int WA    = ID_BITS - S;
    localparam int L1B   = (WA < S) ? WA : S;
    localparam int TA    = WA - L1B;
    localparam int L1W   = 1 << L1B;
    localparam int TOPN  = 1 << TA;
    localparam int WA_W  = (WA > 0) ? WA : 1;
    localparam int TA_W  = (TA > 0) ? TA : 1;
    localparam int L1B_W = (L1B > 0) ? L1B : 1;
    localparam int CNT_W = ID_BITS + 1;

    function automatic logic [TA_W-1:0] ffs_top(input logic [TOPN-1:0] v);
        logic [TA_W-1:0] r;
        r = '0;
        for (int k = TOPN - 1; k >= 0; k--)
        begin
            if (v[k])
            begin
                r = TA_W'(k);
            end
        end
        return r;
    endfunction

    function automatic logic [L1B_W-1:0] ffs_l1(input logic [L1W-1:0] v);
        logic [L1B_W-1:0] r;
        r = '0;
        for (int k = L1W - 1; k >= 0; k--)
        begin
            if (v[k])
            begin
                r = L1B_W'(k);
            end
        end
        return r;
    endfunction

    function automatic logic [S-1:0] ffs_dat(input logic [DW-1:0] v);
        logic [S-1:0] r;
        r = '0;
        for (int k = DW - 1; k >= 0; k--)
        begin
            if (v[k])
            begin
                r = S'(k);
            end
        end
        return r;
    endfunction

    // memories: a word is only trusted when its summary bit is set
    logic [L1W-1:0] l1_mem  [0:TOPN-1];
    logic [DW-1:0]  dat_mem [0:(1 << WA)-1];

    logic [1:0]          req_reg;
    logic [ID_BITS-1:0]  id_reg;
    logic [TA_W-1:0]     t_reg;
    logic [L1B_W-1:0]    i_reg;
    logic [WA_W-1:0]     a_reg;
    logic                hit_reg;
    logic [L1W-1:0]      l1_rd_reg;
    logic [DW-1:0]       dat_rd_reg;

    logic [TOPN-1:0]     top_reg;
    logic [TOPN-1:0]     top_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                last_valid_reg;
    logic                last_valid_next;
    logic [ID_BITS-1:0]  last_id_reg;
    logic [ID_BITS-1:0]  last_id_next;
    logic                out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic                is_pop;
    logic [WA_W-1:0]     id_word;
    logic [S-1:0]        id_bit;
    logic [TA_W-1:0]     id_top;
    logic [L1B_W-1:0]    id_l1bit;
    logic [TA_W-1:0]     top_first;
    logic [TA_W-1:0]     l1_raddr;
    logic [L1B_W-1:0]    l1_first;
    logic [WA_W-1:0]     dat_raddr;
    logic [L1W-1:0]      l1_eff;
    logic [DW-1:0]       dat_eff;
    logic [S-1:0]        dat_first;
    logic [S-1:0]        bsel;
    logic [DW-1:0]       onehot_b;
    logic [L1W-1:0]      onehot_i;
    logic [DW-1:0]       dat_new;
    logic [L1W-1:0]      l1_new;
    logic                dat_we;
    logic                l1_we;
    logic                newly;
    logic                is_set;
    logic                pop_valid;
    logic [ID_BITS-1:0]  popped;

    assign is_pop    = (req_reg == REQ_POP);
    assign id_word   = WA_W'(id_reg >> S);
    assign id_bit    = id_reg[S-1:0];
    assign id_top    = TA_W'(id_reg >> (S + L1B));
    assign id_l1bit  = L1B_W'(id_reg >> S);
    assign top_first = ffs_top(top_reg);
    assign l1_raddr  = is_pop ? top_first : id_top;
    assign l1_first  = ffs_l1(l1_rd_reg);
    assign dat_raddr = cmd.scan ? ((WA_W'(t_reg) << L1B) | WA_W'(l1_first)) : id_word;

    assign stat.pop_hit  = is_pop && (top_reg != '0);
    assign stat.out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        l1_eff    = hit_reg ? l1_rd_reg : '0;
        dat_eff   = l1_eff[i_reg] ? dat_rd_reg : '0;
        dat_first = ffs_dat(dat_eff);
        bsel      = is_pop ? dat_first : id_bit;
        onehot_b  = DW'(1) << bsel;
        onehot_i  = L1W'(1) << i_reg;
        popped    = (ID_BITS'(a_reg) << S) | ID_BITS'(bsel);

        dat_new         = dat_eff;
        l1_new          = l1_eff;
        dat_we          = 1'b0;
        l1_we           = 1'b0;
        newly           = 1'b0;
        is_set          = 1'b0;
        pop_valid       = 1'b0;
        top_next        = top_reg;
        count_next      = count_reg;
        last_valid_next = last_valid_reg;
        last_id_next    = last_id_reg;

        case (req_reg)
            REQ_MARK:
            begin
                newly           = !dat_eff[bsel];
                dat_new         = dat_eff | onehot_b;
                l1_new          = l1_eff | onehot_i;
                dat_we          = cmd.commit;
                l1_we           = cmd.commit;
                top_next[t_reg] = 1'b1;
                count_next      = count_reg + CNT_W'(newly);
                last_valid_next = 1'b0;
                last_id_next    = '0;
            end
            REQ_QUERY:
            begin
                is_set = dat_eff[bsel];
            end
            REQ_POP:
            begin
                pop_valid = hit_reg;
                if (hit_reg)
                begin
                    dat_new = dat_eff & ~onehot_b;
                    // word emptied: drop its summary bit, then maybe the top bit
                    l1_new  = (dat_new == '0) ? (l1_eff & ~onehot_i) : l1_eff;
                    dat_we  = cmd.commit;
                    l1_we   = cmd.commit;
                    if (l1_new == '0)
                    begin
                        top_next[t_reg] = 1'b0;
                    end
                    last_valid_next = 1'b1;
                    last_id_next    = popped;
                end
                else
                begin
                    last_valid_next = 1'b0;
                    last_id_next    = '0;
                end
                if (count_reg != '0)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                top_next = top_reg;
            end
        endcase
    end

    // memory ports and payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= s_tuser;
            id_reg  <= ID_BITS'(s_tdata);
        end
        if (cmd.look)
        begin
            l1_rd_reg <= l1_mem[l1_raddr];
            if (is_pop)
            begin
                t_reg   <= top_first;
                hit_reg <= (top_reg != '0);
            end
            else
            begin
                t_reg   <= id_top;
                i_reg   <= id_l1bit;
                a_reg   <= id_word;
                hit_reg <= top_reg[id_top];
            end
        end
        if (cmd.look || cmd.scan)
        begin
            dat_rd_reg <= dat_mem[dat_raddr];
        end
        if (cmd.scan)
        begin
            i_reg <= l1_first;
            a_reg <= dat_raddr;
        end
        if (l1_we)
        begin
            l1_mem[t_reg] <= l1_new;
        end
        if (dat_we)
        begin
            dat_mem[a_reg] <= dat_new;
        end
        if (cmd.commit)
        begin
            out_data_reg <= {3'b000,
                             PID_W'(last_id_next),
                             last_valid_next,
                             CNT_OUT_W'(count_next),
                             pop_valid ? PID_W'(popped) : PID_W'(0),
                             pop_valid,
                             is_set,
                             newly};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg        <= '0;
            count_reg      <= '0;
            last_valid_reg <= 1'b0;
            last_id_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                top_reg        <= top_next;
                count_reg      <= count_next;
                last_valid_reg <= last_valid_next;
                last_id_reg    <= last_id_next;
                out_valid_reg  <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // an empty set must carry a zero count
    `BIPM_ASSERT_NOW(a_empty_count, top_reg == '0, count_reg == '0)
    // a committed mark leaves its summary path set
    `BIPM_ASSERT_NEXT(a_mark_top, cmd.commit && (req_reg == REQ_MARK), top_reg[t_reg])
    // a successful pop is recorded as the last popped id
    `BIPM_ASSERT_NEXT(a_pop_last, cmd.commit && is_pop && hit_reg, last_valid_reg)
    // the word scan only runs for a pop that found a nonempty top summary
    `BIPM_ASSERT_NOW(a_scan_hit, cmd.scan, hit_reg && is_pop)

endmodule

@@ rtl/bitmap_id_set_pop_min.sv @@
// top level of the marked id set with pop of the smallest id
//
//  beat       group          payload
//  request    s_t*           tuser = req_type, tdata = id
//  result     m_t*           tdata = newly_marked .. last_id (see port)
//
// mark, query, the unused code and a pop on an empty set run accept,
// summary lookup and update; a pop that finds a marked id adds a word scan
// after the lookup. The steps follow the registered reads of the summary and
// bitmap memories, with the top summary in flops searched combinationally.
// reset clears the top summary, count and last popped record at once; no
// clearing pass runs, words behind a clear summary bit read as empty.
// a result waiting on m_tready holds the block in its update step.
`timescale 1ns / 1ps

module bitmap_id_set_pop_min
    import bipm_pkg::*;
#(
    parameter int ID_BITS   = 16,
    parameter int WORD_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] id
    input  logic [IN_USER_W-1:0]  s_tuser,   // [1:0] req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] newly_marked, [1] is_set, [2] pop_valid, [18:3] popped_id,
    // [35:19] marked_count, [36] last_valid, [52:37] last_id, [55:53] zero
    output logic [OUT_DATA_W-1:0] m_tdata
);

    bipm_cmd_t  cmd;
    bipm_stat_t stat;

    bipm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bipm_dp #(
        .ID_BITS   (ID_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule
